>>> rtl/tbfd_pkg.sv
package tbfd_pkg;

  localparam int ThrW   = 12;
  localparam int ShrW   = 18;
  localparam int RegW   = 19;
  localparam int RptW   = 8;
  localparam int DemW   = ThrW + RptW;
  localparam int UnitW  = 2;
  localparam int WarpW  = 7;
  localparam int CfgW   = 19;
  localparam int CfgIdxW = 2;

  localparam logic [ThrW-1:0] ThrLimitReset = 12'd2048;
  localparam logic [ShrW-1:0] ShrLimitReset = 18'd131072;
  localparam logic [RegW-1:0] RegLimitReset = 19'd262144;
  localparam logic [WarpW-1:0] WarpMax      = 7'd127;

  typedef enum logic {
    REQ_SCHEDULE = 1'b0,
    REQ_COMPLETE = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_SCHEDULED = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_COMPLETED = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THREAD_LIMIT   = 2'd0,
    CFG_SHARED_LIMIT   = 2'd1,
    CFG_REGISTER_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE  = 2'd0,
    FSM_MUL   = 2'd1,
    FSM_APPLY = 2'd2,
    FSM_WARP  = 2'd3
  } fsm_e;

  typedef struct packed {
    logic capture;
    logic mult;
    logic apply;
    logic load_out;
  } cmd_t;

endpackage

>>> rtl/tbfd_ctrl.sv
module tbfd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tbfd_pkg::cmd_t  cmd_o
);

  tbfd_pkg::fsm_e state_q, state_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tbfd_pkg::FSM_IDLE: begin
        if (in_valid_i) state_d = tbfd_pkg::FSM_MUL;
      end
      tbfd_pkg::FSM_MUL:   state_d = tbfd_pkg::FSM_APPLY;
      tbfd_pkg::FSM_APPLY: state_d = tbfd_pkg::FSM_WARP;
      tbfd_pkg::FSM_WARP: begin
        if (out_free) state_d = tbfd_pkg::FSM_IDLE;
      end
      default: state_d = tbfd_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      tbfd_pkg::FSM_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      tbfd_pkg::FSM_MUL:   cmd_o.mult  = 1'b1;
      tbfd_pkg::FSM_APPLY: cmd_o.apply = 1'b1;
      tbfd_pkg::FSM_WARP:  cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  // a fresh result takes priority over draining the old one
  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbfd_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/tbfd_datapath.sv
module tbfd_datapath #(
  parameter int UNIT_COUNT = 4,
  parameter int WARP_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbfd_pkg::cmd_t                cmd_i,
  input  logic                          cfg_we_i,
  input  logic [tbfd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tbfd_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [tbfd_pkg::UnitW-1:0]    unit_index_i,
  input  logic [tbfd_pkg::ThrW-1:0]     block_threads_i,
  input  logic [tbfd_pkg::ShrW-1:0]     block_shared_bytes_i,
  input  logic [tbfd_pkg::RptW-1:0]     reg_bytes_per_thread_i,
  output logic [1:0]                    status_o,
  output logic [tbfd_pkg::UnitW-1:0]    chosen_unit_o,
  output logic [tbfd_pkg::ThrW-1:0]     unit_threads_o,
  output logic [tbfd_pkg::WarpW-1:0]    unit_warps_o
);

  localparam int ThrW  = tbfd_pkg::ThrW;
  localparam int ShrW  = tbfd_pkg::ShrW;
  localparam int RegW  = tbfd_pkg::RegW;
  localparam int DemW  = tbfd_pkg::DemW;
  localparam int UnitW = tbfd_pkg::UnitW;
  localparam int WarpW = tbfd_pkg::WarpW;
  // ceil division by the warp width as a reciprocal multiply; exact for sums below 2^14
  localparam int WarpShift = 20;
  localparam int unsigned WarpMul = (32'd1 << WarpShift) / WARP_WIDTH + 1;
  localparam int WSumW = ThrW + 1;
  localparam int WProdW = WSumW + WarpShift + 1;

  logic [ThrW-1:0] thr_lim_q;
  logic [ShrW-1:0] shr_lim_q;
  logic [RegW-1:0] reg_lim_q;

  tbfd_pkg::req_e     req_q;
  logic [UnitW-1:0]   unit_q;
  logic [ThrW-1:0]    thr_q;
  logic [ShrW-1:0]    shr_q;
  logic [tbfd_pkg::RptW-1:0] rpt_q;
  logic [DemW-1:0]    dem_reg_q;

  logic [ThrW-1:0] thr_use_q [UNIT_COUNT];
  logic [ShrW-1:0] shr_use_q [UNIT_COUNT];
  logic [RegW-1:0] reg_use_q [UNIT_COUNT];

  logic [ThrW:0]   nt [UNIT_COUNT];
  logic [ShrW:0]   ns [UNIT_COUNT];
  logic [RegW+1:0] nr [UNIT_COUNT];
  logic [UNIT_COUNT-1:0] fit, grant_oh, sel_oh;
  logic            any_fit;
  logic [UnitW-1:0] grant_unit;
  logic [ThrW-1:0]  grant_thr;

  logic [ThrW-1:0] sel_thr, new_thr;
  logic [ShrW-1:0] sel_shr, new_shr;
  logic [RegW-1:0] sel_reg, new_reg;
  logic            hit, under;

  tbfd_pkg::status_e res_status;
  logic [UnitW-1:0]  res_unit;
  logic [ThrW-1:0]   res_thr;

  tbfd_pkg::status_e st_status_q;
  logic [UnitW-1:0]  st_unit_q;
  logic [ThrW-1:0]   st_thr_q;

  logic [WSumW-1:0]  wsum;
  logic [WProdW-1:0] wprod;
  logic [WProdW-WarpShift-1:0] wq;
  logic [WarpW-1:0]  warps;

  tbfd_pkg::status_e status_q;
  logic [UnitW-1:0]  unit_out_q;
  logic [ThrW-1:0]   uthr_q;
  logic [WarpW-1:0]  warps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_lim_q <= tbfd_pkg::ThrLimitReset;
      shr_lim_q <= tbfd_pkg::ShrLimitReset;
      reg_lim_q <= tbfd_pkg::RegLimitReset;
    end else if (cfg_we_i) begin
      case (tbfd_pkg::cfg_idx_e'(cfg_index_i))
        tbfd_pkg::CFG_THREAD_LIMIT:   thr_lim_q <= cfg_wdata_i[ThrW-1:0];
        tbfd_pkg::CFG_SHARED_LIMIT:   shr_lim_q <= cfg_wdata_i[ShrW-1:0];
        tbfd_pkg::CFG_REGISTER_LIMIT: reg_lim_q <= cfg_wdata_i[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= tbfd_pkg::req_e'(req_type_i);
      unit_q <= unit_index_i;
      thr_q  <= block_threads_i;
      shr_q  <= block_shared_bytes_i;
      rpt_q  <= reg_bytes_per_thread_i;
    end
    if (cmd_i.mult) begin
      dem_reg_q <= DemW'(thr_q) * DemW'(rpt_q);
    end
  end

  // first fit: every unit tested at once, lowest index wins
  always_comb begin
    any_fit    = 1'b0;
    grant_unit = '0;
    grant_thr  = '0;
    for (int u = 0; u < UNIT_COUNT; u++) begin
      nt[u] = {1'b0, thr_use_q[u]} + {1'b0, thr_q};
      ns[u] = {1'b0, shr_use_q[u]} + {1'b0, shr_q};
      nr[u] = {2'b0, reg_use_q[u]} + {1'b0, dem_reg_q};
      fit[u] = (nt[u] <= {1'b0, thr_lim_q}) && (ns[u] <= {1'b0, shr_lim_q}) &&
               (nr[u] <= {2'b0, reg_lim_q});
      grant_oh[u] = fit[u] & ~any_fit;
      any_fit     = any_fit | fit[u];
      grant_unit  = grant_unit | (grant_oh[u] ? UnitW'(u) : '0);
      grant_thr   = grant_thr | (grant_oh[u] ? nt[u][ThrW-1:0] : '0);
    end
  end

  always_comb begin
    sel_thr = '0;
    sel_shr = '0;
    sel_reg = '0;
    for (int u = 0; u < UNIT_COUNT; u++) begin
      sel_oh[u] = (int'(unit_q) == u);
      sel_thr = sel_thr | (sel_oh[u] ? thr_use_q[u] : '0);
      sel_shr = sel_shr | (sel_oh[u] ? shr_use_q[u] : '0);
      sel_reg = sel_reg | (sel_oh[u] ? reg_use_q[u] : '0);
    end
  end

  assign hit = |sel_oh;

  // clamp each counter at zero on completion
  always_comb begin
    under   = 1'b0;
    new_thr = sel_thr - thr_q;
    new_shr = sel_shr - shr_q;
    new_reg = RegW'({1'b0, sel_reg} - dem_reg_q);
    if (thr_q > sel_thr) begin
      new_thr = '0;
      under   = 1'b1;
    end
    if (shr_q > sel_shr) begin
      new_shr = '0;
      under   = 1'b1;
    end
    if (dem_reg_q > {1'b0, sel_reg}) begin
      new_reg = '0;
      under   = 1'b1;
    end
  end

  always_comb begin
    if (req_q == tbfd_pkg::REQ_COMPLETE) begin
      res_unit   = unit_q;
      res_status = (hit && under) ? tbfd_pkg::ST_UNDERFLOW : tbfd_pkg::ST_COMPLETED;
      res_thr    = hit ? new_thr : '0;
    end else if (any_fit) begin
      res_unit   = grant_unit;
      res_status = tbfd_pkg::ST_SCHEDULED;
      res_thr    = grant_thr;
    end else begin
      res_unit   = '0;
      res_status = tbfd_pkg::ST_NO_ROOM;
      res_thr    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < UNIT_COUNT; u++) begin
        thr_use_q[u] <= '0;
        shr_use_q[u] <= '0;
        reg_use_q[u] <= '0;
      end
    end else if (cmd_i.apply) begin
      for (int u = 0; u < UNIT_COUNT; u++) begin
        if (req_q == tbfd_pkg::REQ_SCHEDULE) begin
          if (grant_oh[u]) begin
            thr_use_q[u] <= nt[u][ThrW-1:0];
            shr_use_q[u] <= ns[u][ShrW-1:0];
            reg_use_q[u] <= nr[u][RegW-1:0];
          end
        end else if (sel_oh[u]) begin
          thr_use_q[u] <= new_thr;
          shr_use_q[u] <= new_shr;
          reg_use_q[u] <= new_reg;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      st_status_q <= res_status;
      st_unit_q   <= res_unit;
      st_thr_q    <= res_thr;
    end
  end

  assign wsum  = {1'b0, st_thr_q} + WSumW'(WARP_WIDTH - 1);
  assign wprod = WProdW'(wsum) * WProdW'(WarpMul);
  assign wq    = wprod[WProdW-1:WarpShift];
  assign warps = (wq > (WProdW-WarpShift)'(tbfd_pkg::WarpMax)) ?
                 tbfd_pkg::WarpMax : wq[WarpW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_q   <= st_status_q;
      unit_out_q <= st_unit_q;
      uthr_q     <= st_thr_q;
      warps_q    <= warps;
    end
  end

  assign status_o       = status_q;
  assign chosen_unit_o  = unit_out_q;
  assign unit_threads_o = uthr_q;
  assign unit_warps_o   = warps_q;

endmodule

>>> rtl/thread_block_first_fit_dispatcher.sv
// Thread-block dispatcher with first-fit placement over UNIT_COUNT compute units.
// Request channel (in_valid_i / in_ready_o): a schedule transaction places a block
// on the lowest-numbered unit whose thread, shared-memory and register totals stay
// within the limits; a complete transaction releases a block from the named unit,
// clamping each counter at zero and flagging it in the status.
// Result channel (out_valid_o / out_ready_i): exactly one transaction per request,
// carrying status, unit, the unit's thread count and its warp count.
// Configuration: cfg_we_i writes one limit per cycle, selected by cfg_index_i;
// write only while no request is in flight.
// Sequencing: one request at a time through a four-state sequencer (accept, register
// demand multiply, fit test and counter update, warp count). The result register
// loads in the warp stage, and a new request is taken only once the sequencer is
// back in idle, so requests never overlap.
// Stall: if the result register is still occupied the sequencer holds in its warp
// stage and input ready stays low until the result register frees.
// Reset: all usage counters clear, limits return to 2048 threads, 128 KiB shared
// and 256 KiB register bytes, and both channels come up empty.
module thread_block_first_fit_dispatcher #(
  parameter int UNIT_COUNT = 4,
  parameter int WARP_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [18:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [1:0]  unit_index_i,
  input  logic [11:0] block_threads_i,
  input  logic [17:0] block_shared_bytes_i,
  input  logic [7:0]  reg_bytes_per_thread_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  chosen_unit_o,
  output logic [11:0] unit_threads_o,
  output logic [6:0]  unit_warps_o
);

  // command bundle from the sequencer to the datapath
  tbfd_pkg::cmd_t cmd;

  tbfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // holds limits, per-unit counters, fit test and result registers
  tbfd_datapath #(
    .UNIT_COUNT (UNIT_COUNT),
    .WARP_WIDTH (WARP_WIDTH)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .req_type_i             (req_type_i),
    .unit_index_i           (unit_index_i),
    .block_threads_i        (block_threads_i),
    .block_shared_bytes_i   (block_shared_bytes_i),
    .reg_bytes_per_thread_i (reg_bytes_per_thread_i),
    .status_o               (status_o),
    .chosen_unit_o          (chosen_unit_o),
    .unit_threads_o         (unit_threads_o),
    .unit_warps_o           (unit_warps_o)
  );

endmodule

>>> rtl/tbfd_checker.sv
module tbfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [1:0]  chosen_unit_o,
  input logic [11:0] unit_threads_o,
  input logic [6:0]  unit_warps_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(chosen_unit_o) && $stable(unit_threads_o) && $stable(unit_warps_o))
    else $error("result changed while stalled");

  // one request in flight: ready drops after each accepted transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one in flight");

  a_no_room_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == tbfd_pkg::ST_NO_ROOM |->
      chosen_unit_o == 2'd0 && unit_threads_o == 12'd0 && unit_warps_o == 7'd0)
    else $error("no-room result carries a unit");

  a_warps_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((unit_threads_o == 12'd0) == (unit_warps_o == 7'd0)))
    else $error("warp count disagrees with thread count");

endmodule

bind thread_block_first_fit_dispatcher tbfd_checker u_tbfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .chosen_unit_o  (chosen_unit_o),
  .unit_threads_o (unit_threads_o),
  .unit_warps_o   (unit_warps_o)
);
